### design/b64enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared types, constants and the sextet-to-ASCII mapping.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    typedef logic [1:0] pads_t;

    localparam pads_t PADS_NONE = 2'd0;
    localparam pads_t PADS_ONE  = 2'd1;
    localparam pads_t PADS_TWO  = 2'd2;

    // One 3-byte group ready for output, with its padding and end flag.
    typedef struct packed {
        logic [23:0] triple;
        pads_t       pads;
        logic        last;
    } group_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = PLUS_CHAR;
        else
            c = SLASH_CHAR;
        return c;
    endfunction

endpackage

### design/b64enc_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one message byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### design/b64enc_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one encoded character and its end flag.
// ----------------------------------------------------------------------------
interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink (input valid, input out_char, input last_char, output ready);
endinterface

### design/b64enc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Collects bytes into 3-byte groups and hands each finished group to the queue.
// ----------------------------------------------------------------------------
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    b64enc_byte_if.sink    msg,
    output logic           push,
    output group_t         push_group,
    input  logic           push_ready
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] first_reg;
    logic [7:0] second_reg;
    logic       accept;
    logic       group_full;

    assign msg.ready = push_ready;
    assign accept    = msg.valid && push_ready;
    // Position three cannot occur; it is treated like the third byte slot.
    assign group_full = pos_reg[1];
    assign push       = accept && (group_full || msg.last_byte);

    always_comb
    begin
        push_group = '0;
        pos_next   = pos_reg;
        if (group_full)
        begin
            push_group.triple = {first_reg, second_reg, msg.data_byte};
            push_group.pads   = PADS_NONE;
            push_group.last   = msg.last_byte;
        end
        else if (pos_reg == 2'd1)
        begin
            push_group.triple = {first_reg, msg.data_byte, 8'h00};
            push_group.pads   = PADS_ONE;
            push_group.last   = 1'b1;
        end
        else
        begin
            push_group.triple = {msg.data_byte, 16'h0000};
            push_group.pads   = PADS_TWO;
            push_group.last   = 1'b1;
        end
        if (accept)
        begin
            if (group_full || msg.last_byte)
                pos_next = 2'd0;
            else
                pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 2'd0;
        else
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !msg.last_byte && pos_reg == 2'd0)
            first_reg <= msg.data_byte;
        if (accept && !msg.last_byte && pos_reg == 2'd1)
            second_reg <= msg.data_byte;
    end

endmodule

### design/b64enc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Short FIFO of finished groups between the front and back ends.
// ----------------------------------------------------------------------------
module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  group_t push_group,
    output logic   push_ready,
    input  logic   pop,
    output group_t pop_group,
    output logic   pop_valid
);

    group_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_group  = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] n;
        if (p == Q_PTR_W'(Q_DEPTH - 1))
            n = '0;
        else
            n = p + Q_PTR_W'(1);
        return n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_group;
    end

endmodule

### design/b64enc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Turns each queued group into four characters, one per cycle while the
// receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    input  group_t        pop_group,
    output logic          pop,
    b64enc_char_if.source enc
);

    group_t     grp_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    logic       load;
    logic [5:0] sextet;
    logic [7:0] char_next;
    logic       last_next;
    logic [2:0] pad_sum;

    assign enc.valid     = valid_reg;
    assign enc.out_char  = char_reg;
    assign enc.last_char = last_reg;

    // The output register can take a new character when empty or draining.
    assign load = !valid_reg || enc.ready;
    // Fetch a group when idle, or as the last character of the current one is loaded.
    assign pop  = !busy_reg || (load && idx_reg == 2'd3);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = grp_reg.triple[23:18];
            2'd1:    sextet = grp_reg.triple[17:12];
            2'd2:    sextet = grp_reg.triple[11:6];
            2'd3:    sextet = grp_reg.triple[5:0];
            default: sextet = grp_reg.triple[5:0];
        endcase
        pad_sum = {1'b0, idx_reg} + {1'b0, grp_reg.pads};
        if (pad_sum[2])
            char_next = PAD_CHAR;
        else
            char_next = sextet_char(sextet);
        last_next = grp_reg.last && (idx_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                valid_reg <= busy_reg;
            if (busy_reg && load)
                idx_reg <= idx_reg + 2'd1;
            if (pop)
                busy_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_valid)
            grp_reg <= pop_group;
        if (load && busy_reg)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

endmodule

### design/base64_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder core
// Streaming standard-alphabet Base64 encoder with '=' padding.
// ----------------------------------------------------------------------------
// The msg channel takes one message byte per transfer, and last_byte marks
// the final byte of a message. The enc channel delivers one ASCII character
// per transfer, with last_char on the final character, which is a pad when
// the message length is not a multiple of three. A byte can be taken in every
// cycle while the group queue has room; each group of up to three bytes yields
// four characters, and the single-character output register, which sends one
// character at a time, limits the sustained rate. A two-entry group queue lets
// the input keep accepting bytes while earlier groups are still being sent. Each
// group passes the queue and group register before reaching the output register.
module base64_encoder_core
    import b64enc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    b64enc_byte_if.sink   msg,
    b64enc_char_if.source enc
);

    logic   push;
    group_t push_group;
    logic   push_ready;
    logic   pop;
    group_t pop_group;
    logic   pop_valid;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .push       (push),
        .push_group (push_group),
        .push_ready (push_ready)
    );

    b64enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_group  (pop_group),
        .pop_valid  (pop_valid)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_group (pop_group),
        .pop       (pop),
        .enc       (enc)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder core testbench
// Sends messages as byte transfers under random gaps and output
// stalls, encodes each accepted byte in a local model of the encoder, and
// checks every character transfer in order against the characters the
// model expects.
// ----------------------------------------------------------------------------
module tb_top
    import b64enc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_MAX   = 10;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic clk;
    logic rst_n;

    b64enc_byte_if msg_if ();
    b64enc_char_if enc_if ();

    base64_encoder_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .enc   (enc_if)
    );

    // Local encoder state.
    logic [7:0] pend_first;
    logic [7:0] pend_second;
    logic [1:0] grp_fill;

    enc_char_t expected_chars[$];

    int unsigned error_count;
    int unsigned cycle_count;

    // Sender burst control.
    int unsigned gap_max;
    int unsigned burst_max;
    int unsigned burst_left;

    // Receiver stall control.
    logic        rx_always_ready;
    logic [31:0] rx_pattern;
    int unsigned rx_bits_left;
    int unsigned hold_request;
    int unsigned hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    // Encodes one accepted byte and queues the characters it releases.
    task automatic encode_byte(input logic [7:0] d, input logic l);
        logic [23:0] triple;
        pads_t       pads;
        logic        emit;
        enc_char_t   c;
        emit   = 1'b1;
        triple = '0;
        pads   = PADS_NONE;
        case (grp_fill)
            2'd1:
            begin
                if (!l)
                begin
                    pend_second = d;
                    grp_fill    = 2'd2;
                    emit        = 1'b0;
                end
                else
                begin
                    triple = {pend_first, d, 8'h00};
                    pads   = PADS_ONE;
                end
            end
            2'd2:
            begin
                triple = {pend_first, pend_second, d};
                pads   = PADS_NONE;
            end
            default:
            begin
                if (!l)
                begin
                    pend_first = d;
                    grp_fill   = 2'd1;
                    emit       = 1'b0;
                end
                else
                begin
                    triple = {d, 16'h0000};
                    pads   = PADS_TWO;
                end
            end
        endcase
        if (emit)
        begin
            for (int k = 0; k < 4; k++)
            begin
                c.ch   = (k >= 4 - int'(pads)) ? PAD_CHAR
                                               : b64_char(triple[18 - 6 * k +: 6]);
                c.last = l && (k == 3);
                expected_chars.push_back(c);
            end
            pend_first  = 8'h00;
            pend_second = 8'h00;
            grp_fill    = 2'd0;
        end
    endtask

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    // Character checker.
    always @(posedge clk)
    begin
        enc_char_t want;
        if (rst_n && enc_if.valid && enc_if.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                note_failure($sformatf("unexpected char %h last %b",
                                       enc_if.out_char, enc_if.last_char));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (enc_if.out_char !== want.ch || enc_if.last_char !== want.last)
                    note_failure($sformatf("char exp %h/%b got %h/%b",
                                           want.ch, want.last,
                                           enc_if.out_char, enc_if.last_char));
            end
        end
    end

    // Receiver: random stall patterns, or a counted hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            enc_if.ready <= 1'b0;
            hold_left--;
        end
        else if (rx_always_ready)
        begin
            enc_if.ready <= 1'b1;
        end
        else
        begin
            if (rx_bits_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    rx_pattern = $urandom() & $urandom();
                else
                    rx_pattern = $urandom() | $urandom();
                rx_bits_left = 32;
            end
            enc_if.ready <= rx_pattern[0];
            rx_pattern = rx_pattern >> 1;
            rx_bits_left--;
        end
    end

    // Offers one byte, with a random gap ahead of each burst, and returns
    // after the transfer.
    task automatic send_byte(input logic [7:0] d, input logic l);
        int unsigned gap;
        if (gap_max != 0 && burst_left == 0)
        begin
            msg_if.valid <= 1'b0;
            gap = $urandom_range(1, gap_max);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, burst_max);
        end
        if (burst_left != 0)
            burst_left--;
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= d;
        msg_if.last_byte <= l;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        encode_byte(d, l);
    endtask

    task automatic send_idle();
        msg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_message(input int unsigned len);
        logic [7:0] d;
        for (int unsigned i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       d = 8'h00;
                1:       d = 8'hFF;
                default: d = 8'($urandom());
            endcase
            send_byte(d, i == len - 1);
        end
    endtask

    function automatic int unsigned pick_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 24);
        return $urandom_range(1, 9);
    endfunction

    task automatic wait_drain();
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_short_messages();
        // One-byte and two-byte messages take the padded paths.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_full_groups();
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // Every sextet is 62, the plus character.
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        // A full group without the end flag, then a two-byte tail.
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h31, 1'b1);
    endtask

    task automatic test_random_messages(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items)
        begin
            len = pick_length();
            send_message(len);
            sent += len;
        end
    endtask

    task automatic test_backpressure();
        // The receiver holds off long enough for the group queue to fill
        // and the input to stall while bytes keep coming.
        gap_max      = 0;
        hold_request = 300;
        send_message(7);
        send_message(12);
        send_message(2);
        send_message(19);
        gap_max = 6;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 6; i++)
        begin
            send_message($urandom_range(1, 9));
            send_idle();
            wait_drain();
        end
    endtask

    task automatic test_back_to_back();
        rx_always_ready = 1'b1;
        gap_max         = 0;
        test_random_messages(60);
        rx_always_ready = 1'b0;
        gap_max         = 6;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        msg_if.valid     = 1'b0;
        msg_if.data_byte = 8'h00;
        msg_if.last_byte = 1'b0;
        enc_if.ready     = 1'b0;
        pend_first       = 8'h00;
        pend_second      = 8'h00;
        grp_fill         = 2'd0;
        error_count      = 0;
        cycle_count      = 0;
        gap_max          = 6;
        burst_max        = 8;
        burst_left       = 0;
        rx_always_ready  = 1'b0;
        rx_pattern       = '0;
        rx_bits_left     = 0;
        hold_request     = 0;
        hold_left        = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_full_groups();
        test_random_messages(260);
        test_backpressure();
        test_drain_pause();
        test_back_to_back();

        send_idle();
        wait_drain();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
